// ===== sv/tsfu_pkg.sv =====
// ----------------------------------------------------------------------------
// tsfu_pkg: shared types and constants of the Taylor series function unit
// Function codes, fixed-point widths and the controller/datapath link.
// ----------------------------------------------------------------------------
package tsfu_pkg;

  localparam int TSFU_MAX_TERMS = 16;
  localparam int TSFU_FRAC_BITS = 24;

  localparam logic [2:0] CMD_SIN  = 3'd0;
  localparam logic [2:0] CMD_COS  = 3'd1;
  localparam logic [2:0] CMD_SINH = 3'd2;
  localparam logic [2:0] CMD_COSH = 3'd3;
  localparam logic [2:0] CMD_EXP  = 3'd4;

  localparam int CMD_W   = 3;
  localparam int ANGLE_W = 10;
  localparam int TC_W    = 5;
  localparam int VALUE_W = 48;

  // term magnitude, clamped to 2^56
  localparam int T_W = 57;
  localparam int M_W = 17;
  localparam int DEG_NUM = 157;
  localparam int DEG_DEN = 9000;
  // divisor 9000*k, k below 64
  localparam int DIV_W = 20;
  // dividend t*m below 2^74, padded to a whole number of divider cycles
  localparam int NUM_W     = 76;
  localparam int DIV_STEPS = 4;
  localparam int DIV_CYC   = NUM_W / DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_CYC);

  localparam logic [T_W-1:0] TERM_CAP = {1'b1, {(T_W-1){1'b0}}};
  localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] OUT_MIN = 64'shFFFF_8000_0000_0000;

  typedef struct packed {
    logic load;
    logic exp_one;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic clamp;
    logic add;
    logic sub;
    logic out_load;
  } tsfu_cmd_t;

  typedef struct packed {
    logic neg;
  } tsfu_sts_t;

endpackage

// ===== sv/tsfu_dp.sv =====
// ----------------------------------------------------------------------------
// tsfu_dp: datapath of the Taylor series function unit
// Term register, split multiplier, radix-16 restoring divider and accumulator.
// ----------------------------------------------------------------------------
module tsfu_dp import tsfu_pkg::*; #(
  parameter int FRAC_BITS = TSFU_FRAC_BITS
) (
  input  logic                      clk,
  input  logic signed [ANGLE_W-1:0] in_angle_deg,
  input  tsfu_cmd_t                 cmd,
  output tsfu_sts_t                 sts,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_overflow
);

  localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

  logic [ANGLE_W-1:0]        mag;
  logic                      neg_r;
  logic [M_W-1:0]            m_r;
  logic [T_W-1:0]            t_r;
  logic [48:0]               prod_r;
  logic [NUM_W-1:0]          num_r;
  logic [NUM_W-1:0]          num_nxt;
  logic [DIV_W-1:0]          rem_r;
  logic [DIV_W-1:0]          rem_nxt;
  logic [DIV_W-1:0]          d_r;
  logic signed [63:0]        sum_r;
  logic signed [VALUE_W-1:0] value_r;
  logic                      ovf_r;
  logic [41:0]               prod_hi;

  assign mag = in_angle_deg[ANGLE_W-1] ? (~in_angle_deg + ANGLE_W'(1)) : in_angle_deg;
  assign prod_hi = 42'(t_r[T_W-1:32]) * 42'(m_r);

  always_comb begin
    logic [DIV_W:0]   trial;
    logic [DIV_W-1:0] rq;
    logic [NUM_W-1:0] nq;
    rq = rem_r;
    nq = num_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = {rq, nq[NUM_W-1]};
      if (trial >= {1'b0, d_r}) begin
        trial = trial - {1'b0, d_r};
        nq = {nq[NUM_W-2:0], 1'b1};
      end else begin
        nq = {nq[NUM_W-2:0], 1'b0};
      end
      rq = trial[DIV_W-1:0];
    end
    rem_nxt = rq;
    num_nxt = nq;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r <= in_angle_deg[ANGLE_W-1];
      m_r   <= M_W'(mag) * M_W'(DEG_NUM);
      t_r   <= ONE;
      d_r   <= '0;
      sum_r <= cmd.exp_one ? 64'(ONE) : 64'sd0;
    end
    if (cmd.mul_lo) begin
      prod_r <= 49'(t_r[31:0]) * 49'(m_r);
      d_r    <= d_r + DIV_W'(DEG_DEN);
    end
    if (cmd.mul_hi) begin
      num_r <= (NUM_W'(prod_hi) << 32) + NUM_W'(prod_r);
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
    if (cmd.clamp) begin
      t_r <= (num_r > NUM_W'(TERM_CAP)) ? TERM_CAP : num_r[T_W-1:0];
    end
    if (cmd.add) begin
      sum_r <= sum_r + $signed(64'(t_r));
    end
    if (cmd.sub) begin
      sum_r <= sum_r - $signed(64'(t_r));
    end
    if (cmd.out_load) begin
      if (sum_r > OUT_MAX) begin
        value_r <= OUT_MAX[VALUE_W-1:0];
        ovf_r   <= 1'b1;
      end else if (sum_r < OUT_MIN) begin
        value_r <= OUT_MIN[VALUE_W-1:0];
        ovf_r   <= 1'b1;
      end else begin
        value_r <= sum_r[VALUE_W-1:0];
        ovf_r   <= 1'b0;
      end
    end
  end

  assign sts.neg      = neg_r;
  assign out_value    = value_r;
  assign out_overflow = ovf_r;

endmodule

// ===== sv/tsfu_ctrl.sv =====
// ----------------------------------------------------------------------------
// tsfu_ctrl: controller of the Taylor series function unit
// Sequences powers, divides and term accumulation; owns handshakes and config.
// ----------------------------------------------------------------------------
module tsfu_ctrl import tsfu_pkg::*; #(
  parameter int MAX_TERMS = TSFU_MAX_TERMS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [CMD_W-1:0] in_cmd,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             cfg_wr_en,
  input  logic [TC_W-1:0]  cfg_wr_data,
  output tsfu_cmd_t        cmd,
  input  tsfu_sts_t        sts
);

  localparam int NW   = $clog2(MAX_TERMS + 1);
  localparam int PW_W = NW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_MLO  = 3'd2;
  localparam logic [2:0] S_MHI  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_CLP  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [TC_W-1:0]   term_count_r;
  logic [CMD_W-1:0]  cmd_r;
  logic [NW-1:0]     n_r, n_in;
  logic [NW-1:0]     i_r, i_nxt;
  logic [PW_W-1:0]   pw_r, pw_nxt;
  logic [PW_W-1:0]   target;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              out_valid_r;
  logic              accept;
  logic              minus;
  logic              alt;

  assign n_in   = (int'(term_count_r) > MAX_TERMS) ? NW'(MAX_TERMS) : NW'(term_count_r);
  assign accept = in_valid && in_ready;
  assign alt    = (cmd_r == CMD_SIN) || (cmd_r == CMD_COS);
  assign minus  = (sts.neg & pw_r[0]) ^ (alt & i_r[0]);

  always_comb begin
    unique case (cmd_r)
      CMD_SIN, CMD_SINH: target = {i_r, 1'b1};
      CMD_COS, CMD_COSH: target = {i_r, 1'b0};
      default:           target = PW_W'(i_r);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    pw_nxt    = pw_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.exp_one = (in_cmd == CMD_EXP) && (n_in == '0);
          i_nxt       = '0;
          pw_nxt      = '0;
          state_nxt   = (in_cmd > CMD_EXP) ? S_FIN : S_CHK;
        end
      end
      S_CHK: begin
        if (i_r == n_r) begin
          state_nxt = S_FIN;
        end else if (pw_r < target) begin
          pw_nxt    = pw_r + PW_W'(1);
          state_nxt = S_MLO;
        end else begin
          cmd.add = !minus;
          cmd.sub = minus;
          i_nxt   = i_r + NW'(1);
        end
      end
      S_MLO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MHI;
      end
      S_MHI: begin
        cmd.mul_hi = 1'b1;
        dcnt_nxt   = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_CYC - 1)) begin
          state_nxt = S_CLP;
        end
      end
      S_CLP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_CHK;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      term_count_r <= TC_W'(8);
      out_valid_r  <= 1'b0;
      i_r          <= '0;
      pw_r         <= '0;
      dcnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      pw_r    <= pw_nxt;
      dcnt_r  <= dcnt_nxt;
      if (cfg_wr_en) begin
        term_count_r <= cfg_wr_data;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_cmd;
      n_r   <= n_in;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken beat");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MHI) |=> (state_r == S_DIV) && (dcnt_r == '0))
    else $error("divider did not start from step zero");

  a_pw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (int'(pw_r) <= 2 * MAX_TERMS - 1))
    else $error("power index past the last series term");

  a_term_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK) |-> (i_r <= n_r))
    else $error("term index past term count");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken again before item finished");

endmodule

// ===== sv/taylor_series_function_unit.sv =====
// ----------------------------------------------------------------------------
// taylor_series_function_unit: truncated Taylor series sin/cos/sinh/cosh/exp
// Top level joining the sequencing controller and the arithmetic datapath.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): a beat carries in_cmd (0 sin, 1 cos,
// 2 sinh, 3 cosh, 4 exp) and in_angle_deg in whole degrees; radians are
// taken as degrees * 3.14/180. Output channel (out_valid/out_ready): a beat
// carries out_value, signed with FRAC_BITS fraction bits, saturated to
// 48 bits, and out_overflow when it saturated.
// cfg_wr_en/cfg_wr_data set term_count (reset 8, capped at MAX_TERMS); write
// it only while the unit is idle.
// One item at a time. With P the highest power the series reaches (2n-1 for
// sin/sinh, 2n-2 for cos/cosh, n-1 for exp, n terms) an item raises its term
// P times: each power passes a check state, the low 32x17 and high 25x17
// products, the 4-bit-per-cycle divider and a clamp state. Each term is
// then added in a check state. Unused codes skip the series and return zero.
// A finished result sits in the output register; the next item is accepted
// while it waits, and finishes only once the receiver takes it.
// Synchronous reset clears control and sets term_count to 8.
// ----------------------------------------------------------------------------
module taylor_series_function_unit import tsfu_pkg::*; #(
  parameter int MAX_TERMS = TSFU_MAX_TERMS,
  parameter int FRAC_BITS = TSFU_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CMD_W-1:0]          in_cmd,
  input  logic signed [ANGLE_W-1:0] in_angle_deg,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_overflow,
  input  logic                      cfg_wr_en,
  input  logic [TC_W-1:0]           cfg_wr_data
);

  tsfu_cmd_t dp_cmd;
  tsfu_sts_t dp_sts;

  tsfu_ctrl #(
    .MAX_TERMS (MAX_TERMS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_cmd      (in_cmd),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (dp_cmd),
    .sts         (dp_sts)
  );

  tsfu_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .in_angle_deg (in_angle_deg),
    .cmd          (dp_cmd),
    .sts          (dp_sts),
    .out_value    (out_value),
    .out_overflow (out_overflow)
  );

endmodule

// ===== tb/taylor_series_function_unit_test.sv =====
// ----------------------------------------------------------------------------
// taylor_series_function_unit_test: self-checking bench for the series unit
// Drives sin/cos/sinh/cosh/exp and spare-code requests through valid/ready
// input with bursty timing, stalls the result side on its own pattern,
// checks every result beat against a typed value or a fixed-point series
// predictor, and rewrites term_count per phase: zero, the cap, above it.
// ----------------------------------------------------------------------------
module taylor_series_function_unit_test import tsfu_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int SETTLE      = 30;
  localparam int DIR_N       = 24;
  localparam int PHASE_N     = 12;

  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  localparam logic signed [47:0] Q_ZERO = 48'sd0;
  localparam logic signed [47:0] Q_ONE  = 48'sd16777216;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;
  } series_result_t;

  typedef struct packed {
    logic [TC_W-1:0]           terms;
    logic [CMD_W-1:0]          cmd;
    logic signed [ANGLE_W-1:0] angle;
    logic                      typed;
    logic signed [VALUE_W-1:0] value;
  } dir_row_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [CMD_W-1:0]          in_cmd = '0;
  logic signed [ANGLE_W-1:0] in_angle_deg = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_overflow;
  logic                      cfg_wr_en = 1'b0;
  logic [TC_W-1:0]           cfg_wr_data = '0;

  series_result_t pending_results [$];
  series_result_t oldest;
  int             errors = 0;
  int             items_sent = 0;
  int             results_seen = 0;
  int             term_writes = 0;
  int             cycles = 0;
  int             ready_mode = 0;
  int             ready_left = 0;
  logic [TC_W-1:0] terms_now = 5'd8;

  dir_row_t dir_rows [DIR_N] = '{
    '{5'd8,  CMD_SIN,       10'sd0,    1'b1, Q_ZERO},
    '{5'd8,  CMD_COS,       10'sd0,    1'b1, Q_ONE},
    '{5'd8,  CMD_SINH,      10'sd0,    1'b1, Q_ZERO},
    '{5'd8,  CMD_COSH,      10'sd0,    1'b1, Q_ONE},
    '{5'd8,  CMD_EXP,       10'sd0,    1'b1, Q_ONE},
    '{5'd8,  CMD_SPARE_LO,  10'sd90,   1'b1, Q_ZERO},
    '{5'd8,  CMD_SPARE_MID, -10'sd512, 1'b1, Q_ZERO},
    '{5'd8,  CMD_SPARE_HI,  10'sd511,  1'b1, Q_ZERO},
    '{5'd8,  CMD_SIN,       10'sd90,   1'b0, Q_ZERO},
    '{5'd8,  CMD_COS,       -10'sd360, 1'b0, Q_ZERO},
    '{5'd8,  CMD_SINH,      10'sd511,  1'b0, Q_ZERO},
    '{5'd8,  CMD_COSH,      -10'sd512, 1'b0, Q_ZERO},
    '{5'd8,  CMD_EXP,       -10'sd512, 1'b0, Q_ZERO},
    '{5'd8,  CMD_EXP,       10'sd511,  1'b0, Q_ZERO},
    '{5'd8,  CMD_SIN,       -10'sd1,   1'b0, Q_ZERO},
    '{5'd0,  CMD_SIN,       10'sd45,   1'b1, Q_ZERO},
    '{5'd0,  CMD_COS,       10'sd45,   1'b1, Q_ZERO},
    '{5'd0,  CMD_SINH,      -10'sd512, 1'b1, Q_ZERO},
    '{5'd0,  CMD_COSH,      10'sd511,  1'b1, Q_ZERO},
    '{5'd0,  CMD_EXP,       10'sd511,  1'b1, Q_ONE},
    '{5'd0,  CMD_EXP,       -10'sd512, 1'b1, Q_ONE},
    '{5'd31, CMD_SIN,       10'sd511,  1'b0, Q_ZERO},
    '{5'd31, CMD_EXP,       -10'sd512, 1'b0, Q_ZERO},
    '{5'd16, CMD_COS,       10'sd360,  1'b0, Q_ZERO}
  };

  int phase_terms [PHASE_N] = '{2, 5, 0, 16, 3, 31, 1, 7, 4, 10, 6, 8};
  int phase_items [PHASE_N] = '{60, 60, 40, 25, 60, 20, 60, 50, 60, 30, 50, 40};

  taylor_series_function_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_angle_deg (in_angle_deg),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .out_overflow (out_overflow),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // truncated series, terms carried as |x|^k/k! and floored at every power
  function automatic series_result_t predict_series(input logic [CMD_W-1:0] cmd,
                                                    input logic signed [ANGLE_W-1:0] angle,
                                                    input logic [TC_W-1:0] terms);
    series_result_t res;
    logic           neg;
    int unsigned    mag;
    int unsigned    n;
    int unsigned    pw;
    int unsigned    target;
    logic [79:0]    scale;
    logic [79:0]    mag_t;
    longint         acc;
    logic           minus;
    neg   = angle[ANGLE_W-1];
    mag   = neg ? -int'(angle) : int'(angle);
    scale = 80'(mag * DEG_NUM);
    n     = (terms > TSFU_MAX_TERMS) ? TSFU_MAX_TERMS : terms;
    mag_t = 80'd1 << TSFU_FRAC_BITS;
    pw    = 0;
    acc   = 0;
    res   = '0;
    if (cmd > CMD_EXP) return res;
    if (cmd == CMD_EXP && n == 0) acc = longint'(mag_t);
    for (int unsigned i = 0; i < n; i++) begin
      if (cmd == CMD_SIN || cmd == CMD_SINH) begin
        target = 2 * i + 1;
      end else if (cmd == CMD_COS || cmd == CMD_COSH) begin
        target = 2 * i;
      end else begin
        target = i;
      end
      while (pw < target) begin
        pw++;
        mag_t = (mag_t * scale) / 80'(DEG_DEN * pw);
        if (mag_t > 80'(TERM_CAP)) mag_t = 80'(TERM_CAP);
      end
      minus = neg && pw[0];
      if ((cmd == CMD_SIN || cmd == CMD_COS) && i[0]) minus = !minus;
      if (minus) begin
        acc -= longint'(mag_t[63:0]);
      end else begin
        acc += longint'(mag_t[63:0]);
      end
    end
    if (acc > OUT_MAX) begin
      acc = OUT_MAX;
      res.overflow = 1'b1;
    end else if (acc < OUT_MIN) begin
      acc = OUT_MIN;
      res.overflow = 1'b1;
    end
    res.value = acc[VALUE_W-1:0];
    return res;
  endfunction

  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic signed [ANGLE_W-1:0] angle,
                           input series_result_t want);
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_angle_deg <= angle;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(want);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_term_count(input logic [TC_W-1:0] terms);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= terms;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    terms_now = terms;
    term_writes++;
    repeat (2) @(posedge clk);
  endtask

  // receiver: runs of always-ready, coin-flip, full stall and one-in-four
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_left = $urandom_range(1, 40);
    end
    ready_left--;
    case (ready_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_ready <= 1'b0;
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) == 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, value %h overflow %b",
                 $time, out_value, out_overflow);
      end else begin
        oldest = pending_results.pop_front();
        results_seen++;
        if (out_value !== oldest.value) begin
          errors++;
          $display("%0t: value mismatch, expected %h, actual %h", $time, oldest.value, out_value);
        end
        if (out_overflow !== oldest.overflow) begin
          errors++;
          $display("%0t: overflow mismatch, expected %b, actual %b",
                   $time, oldest.overflow, out_overflow);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    series_result_t         want;
    logic [CMD_W-1:0]       cmd;
    logic signed [ANGLE_W-1:0] angle;
    int                     burst_left;
    int                     gap;
    int                     a;
    int                     directed;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].terms != terms_now) begin
        drain_results();
        set_term_count(dir_rows[r].terms);
      end
      if (dir_rows[r].typed) begin
        want = '{value: dir_rows[r].value, overflow: 1'b0};
      end else begin
        want = predict_series(dir_rows[r].cmd, dir_rows[r].angle, terms_now);
      end
      send_beat(dir_rows[r].cmd, dir_rows[r].angle, want);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    directed = items_sent;

    // last phase takes a random setting
    phase_terms[PHASE_N-1] = $urandom_range(0, 31);
    for (int p = 0; p < PHASE_N; p++) begin
      drain_results();
      set_term_count(TC_W'(phase_terms[p]));
      burst_left = 0;
      for (int i = 0; i < phase_items[p]; i++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          if ($urandom_range(0, 29) == 0) begin
            drain_results();
          end else if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        cmd = ($urandom_range(0, 19) < 17) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        if ($urandom_range(0, 9) < 7) begin
          a = int'($urandom_range(0, 720)) - 360;
        end else begin
          a = int'($urandom_range(0, 1023)) - 512;
        end
        angle = a[ANGLE_W-1:0];
        want  = predict_series(cmd, angle, terms_now);
        send_beat(cmd, angle, want);
      end
    end

    drain_results();
    $display("Sent %0d items (%0d directed), checked %0d result beats", items_sent, directed,
             results_seen);
    $display("term_count written %0d times, zero, cap and above cap included", term_writes);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
